// File: design/rgbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared constants for the RGB command smoothing fader: command selectors,
// gain format and reset values.
// ----------------------------------------------------------------------------
package rgbf_pkg;

  // Command selector bytes
  localparam logic [7:0] SEL_RED   = 8'h72;
  localparam logic [7:0] SEL_GREEN = 8'h67;
  localparam logic [7:0] SEL_BLUE  = 8'h62;
  localparam logic [7:0] SEL_NONE  = 8'h00;

  // Gain is unsigned with 16 fraction bits
  localparam int unsigned GainBits  = 16;
  localparam int unsigned GainShift = 16;
  localparam logic [GainBits-1:0] GAIN_RESET = 16'd3277;

  // Integer part of a level
  localparam int unsigned DutyBits = 8;

endpackage
`default_nettype wire

// File: design/rgbf_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbf_channel
// One-pole low-pass step for one color channel:
// next = level + floor(((target << F) - level) * gain / 2^16), wrapped.
// ----------------------------------------------------------------------------
module rgbf_channel
  import rgbf_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic [DutyBits+FRACTION_BITS-1:0] level_i,
  input  wire logic [DutyBits-1:0]               target_i,
  input  wire logic [GainBits-1:0]               gain_i,
  output logic      [DutyBits+FRACTION_BITS-1:0] level_o
);

  localparam int unsigned LevelW = DutyBits + FRACTION_BITS;
  localparam int unsigned ProdW  = LevelW + GainBits + 1;

  logic        [LevelW-1:0] goal;
  logic signed [LevelW:0]   diff;
  logic signed [ProdW-1:0]  diff_ext;
  logic signed [ProdW-1:0]  gain_ext;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  step;

  // Place the target on the level's fixed-point grid
  assign goal = {target_i, {FRACTION_BITS{1'b0}}};

  // Signed error between goal and level
  assign diff = $signed({1'b0, goal}) - $signed({1'b0, level_i});

  // Scale the error by the gain, floor toward minus infinity
  assign diff_ext = ProdW'(diff);
  assign gain_ext = $signed(ProdW'({1'b0, gain_i}));
  assign prod     = diff_ext * gain_ext;
  assign step     = prod >>> GainShift;

  // Advance the level, wrapping to the level width
  assign level_o = level_i + step[LevelW-1:0];

endmodule
`default_nettype wire

// File: design/rgb_command_smoothing_fader.sv
`default_nettype none
// Each result goes to the result register, or to the skid entry if that
// is held. One transaction per cycle while in_stall_o is low; the three
// channel filters update in a single pass of one multiply and add each.
// A two-entry output stage lets input continue while one result waits.
// Reset: gain 3277, targets zero, levels 0.1, no selector pending.
// ----------------------------------------------------------------------------
// rgb_command_smoothing_fader
// Two-byte serial command parser setting RGB targets, followed by three
// exponential moving average filters whose integer parts drive PWM duty.
// ----------------------------------------------------------------------------
module rgb_command_smoothing_fader
  import rgbf_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_wen_i,
  input  wire logic [GainBits-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                byte_valid_i,
  input  wire logic [7:0]          rx_byte_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [DutyBits-1:0] red_duty_o,
  output logic      [DutyBits-1:0] green_duty_o,
  output logic      [DutyBits-1:0] blue_duty_o
);

  localparam int unsigned LevelW = DutyBits + FRACTION_BITS;
  localparam logic [LevelW-1:0] LevelReset =
    LevelW'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

  typedef struct packed {
    logic [DutyBits-1:0] red;
    logic [DutyBits-1:0] green;
    logic [DutyBits-1:0] blue;
  } duty_t;

  logic [GainBits-1:0] gain_q;
  logic [7:0]          sel_q, sel_d;
  logic [7:0]          tgt_r_q, tgt_r_d;
  logic [7:0]          tgt_g_q, tgt_g_d;
  logic [7:0]          tgt_b_q, tgt_b_d;
  logic [LevelW-1:0]   lvl_r_q, lvl_r_d;
  logic [LevelW-1:0]   lvl_g_q, lvl_g_d;
  logic [LevelW-1:0]   lvl_b_q, lvl_b_d;

  logic  in_acc;
  logic  out_take;
  duty_t res;
  duty_t out_q;
  duty_t skid_q;
  logic  out_valid_q;
  logic  skid_valid_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;

  // Hold the gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_wen_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // Parse selector and value bytes
  always_comb begin
    sel_d   = sel_q;
    tgt_r_d = tgt_r_q;
    tgt_g_d = tgt_g_q;
    tgt_b_d = tgt_b_q;
    if (byte_valid_i) begin
      if (sel_q == SEL_NONE) begin
        sel_d = rx_byte_i;
      end else begin
        case (sel_q)
          SEL_RED:   tgt_r_d = rx_byte_i;
          SEL_GREEN: tgt_g_d = rx_byte_i;
          SEL_BLUE:  tgt_b_d = rx_byte_i;
          default:   ;
        endcase
        sel_d = SEL_NONE;
      end
    end
  end

  // Smooth each channel toward its updated target
  rgbf_channel #(.FRACTION_BITS(FRACTION_BITS)) u_red (
    .level_i (lvl_r_q),
    .target_i(tgt_r_d),
    .gain_i  (gain_q),
    .level_o (lvl_r_d)
  );

  rgbf_channel #(.FRACTION_BITS(FRACTION_BITS)) u_green (
    .level_i (lvl_g_q),
    .target_i(tgt_g_d),
    .gain_i  (gain_q),
    .level_o (lvl_g_d)
  );

  rgbf_channel #(.FRACTION_BITS(FRACTION_BITS)) u_blue (
    .level_i (lvl_b_q),
    .target_i(tgt_b_d),
    .gain_i  (gain_q),
    .level_o (lvl_b_d)
  );

  assign res.red   = lvl_r_d[LevelW-1:FRACTION_BITS];
  assign res.green = lvl_g_d[LevelW-1:FRACTION_BITS];
  assign res.blue  = lvl_b_d[LevelW-1:FRACTION_BITS];

  // Advance parser and filter state on each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= SEL_NONE;
      tgt_r_q <= '0;
      tgt_g_q <= '0;
      tgt_b_q <= '0;
      lvl_r_q <= LevelReset;
      lvl_g_q <= LevelReset;
      lvl_b_q <= LevelReset;
    end else if (in_acc) begin
      sel_q   <= sel_d;
      tgt_r_q <= tgt_r_d;
      tgt_g_q <= tgt_g_d;
      tgt_b_q <= tgt_b_d;
      lvl_r_q <= lvl_r_d;
      lvl_g_q <= lvl_g_d;
      lvl_b_q <= lvl_b_d;
    end
  end

  // Output stage control: result register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output stage data
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = out_q.red;
  assign green_duty_o = out_q.green;
  assign blue_duty_o  = out_q.blue;

`ifndef SYNTHESIS
  // Skid entry is only used behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // Every input transaction leaves a result to deliver
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("input transaction produced no result");

  // A selector byte with nothing pending becomes the pending selector
  a_selector_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && byte_valid_i && (sel_q == SEL_NONE)) |=> (sel_q == $past(rx_byte_i)))
    else $error("selector byte not captured");
`endif

endmodule
`default_nettype wire

// File: tb/rgbf_fader_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbf_fader_checker
// Passive checker for the RGB command smoothing fader. It follows the
// gain register and every input transaction with its own parser and filter
// model, and queues the expected duty triple. Each output transaction is
// compared lane by lane with the oldest queued triple.
// ----------------------------------------------------------------------------
module rgbf_fader_checker
  import rgbf_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wen_i,
  input  wire logic [GainBits-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic                byte_valid_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [DutyBits-1:0] red_duty_i,
  input  wire logic [DutyBits-1:0] green_duty_i,
  input  wire logic [DutyBits-1:0] blue_duty_i,
  output int unsigned              fail_count_o,
  output int unsigned              outstanding_o
);

  localparam int unsigned LevelBits = DutyBits + FRACTION_BITS;
  localparam logic [LevelBits-1:0] LevelReset =
    LevelBits'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

  typedef struct packed {
    logic [DutyBits-1:0] red;
    logic [DutyBits-1:0] green;
    logic [DutyBits-1:0] blue;
  } duty_t;

  duty_t duty_q[$];

  logic [GainBits-1:0]  gain_q;
  logic [7:0]           selector_q;
  logic [7:0]           target_red_q;
  logic [7:0]           target_green_q;
  logic [7:0]           target_blue_q;
  logic [LevelBits-1:0] level_red_q;
  logic [LevelBits-1:0] level_green_q;
  logic [LevelBits-1:0] level_blue_q;

  string lane_name [3] = '{"red_duty", "green_duty", "blue_duty"};

  // One-pole low-pass step; the arithmetic shift floors negative steps
  function automatic logic [LevelBits-1:0] ema_update(input logic [LevelBits-1:0] level,
                                                      input logic [7:0]           target,
                                                      input logic [GainBits-1:0]  gain);
    longint goal;
    longint diff;
    longint delta;
    goal  = longint'(target) <<< FRACTION_BITS;
    diff  = goal - longint'(level);
    delta = (diff * longint'(gain)) >>> GainShift;
    return LevelBits'(longint'(level) + delta);
  endfunction

  // Track configuration, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin : track
    duty_t           want;
    duty_t           next;
    logic [7:0]      exp_v [3];
    logic [7:0]      act_v [3];
    bit              bad;
    if (!rst_ni) begin
      gain_q         = GAIN_RESET;
      selector_q     = SEL_NONE;
      target_red_q   = '0;
      target_green_q = '0;
      target_blue_q  = '0;
      level_red_q    = LevelReset;
      level_green_q  = LevelReset;
      level_blue_q   = LevelReset;
      duty_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_wen_i) begin
        gain_q = cfg_wdata_i;
      end

      // Compare the output transaction first, so a same-cycle result
      // never matches the item accepted at this edge
      if (out_valid_i && !out_stall_i) begin
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected output transaction, actual %0d %0d %0d",
                   $time, red_duty_i, green_duty_i, blue_duty_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want  = duty_q.pop_front();
          exp_v = '{want.red, want.green, want.blue};
          act_v = '{red_duty_i, green_duty_i, blue_duty_i};
          bad   = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (exp_v[i] !== act_v[i]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d",
                       $time, lane_name[i], exp_v[i], act_v[i]);
              bad = 1'b1;
            end
          end
          if (bad) begin
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      // Advance the parser and the filters on an input transaction
      if (in_valid_i && !in_stall_i) begin
        if (byte_valid_i) begin
          if (selector_q == SEL_NONE) begin
            selector_q = rx_byte_i;
          end else begin
            case (selector_q)
              SEL_RED:   target_red_q   = rx_byte_i;
              SEL_GREEN: target_green_q = rx_byte_i;
              SEL_BLUE:  target_blue_q  = rx_byte_i;
              default: ;
            endcase
            selector_q = SEL_NONE;
          end
        end
        level_red_q   = ema_update(level_red_q, target_red_q, gain_q);
        level_green_q = ema_update(level_green_q, target_green_q, gain_q);
        level_blue_q  = ema_update(level_blue_q, target_blue_q, gain_q);
        next.red      = level_red_q[LevelBits-1 -: DutyBits];
        next.green    = level_green_q[LevelBits-1 -: DutyBits];
        next.blue     = level_blue_q[LevelBits-1 -: DutyBits];
        duty_q.push_back(next);
      end

      outstanding_o <= duty_q.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/rgb_command_smoothing_fader_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_command_smoothing_fader_tb
// Drives the fader with directed and random serial command streams across
// several gain settings and idle/stall mixes, including a long output hold
// that backs up the input. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module rgb_command_smoothing_fader_tb;
  import rgbf_pkg::*;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 4;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_wen_i    = 1'b0;
  logic [GainBits-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                byte_valid_i = 1'b0;
  logic [7:0]          rx_byte_i    = '0;
  logic                out_stall_i  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [DutyBits-1:0] red_duty_o;
  logic [DutyBits-1:0] green_duty_o;
  logic [DutyBits-1:0] blue_duty_o;

  int unsigned fail_count;
  int unsigned outstanding;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned items_sent     = 0;
  bit          mid_command    = 1'b0;

  always #5 clk_i = ~clk_i;

  rgb_command_smoothing_fader #(
    .FRACTION_BITS(FracBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_valid_i (byte_valid_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_duty_o   (red_duty_o),
    .green_duty_o (green_duty_o),
    .blue_duty_o  (blue_duty_o)
  );

  rgbf_fader_checker #(
    .FRACTION_BITS(FracBits)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .byte_valid_i  (byte_valid_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_duty_i    (red_duty_o),
    .green_duty_i  (green_duty_o),
    .blue_duty_i   (blue_duty_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run after too many cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, with optional idle cycles ahead, and hold until accepted
  task automatic send_item(input logic bv, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    byte_valid_i <= bv;
    rx_byte_i    <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Send a received byte and keep track of the command framing
  task automatic send_byte(input logic [7:0] b);
    send_item(1'b1, b);
    if (mid_command) begin
      mid_command = 1'b0;
    end else if (b != SEL_NONE) begin
      mid_command = 1'b1;
    end
  endtask

  // Send a selector/value pair, closing any open command first
  task automatic send_command(input logic [7:0] sel, input logic [7:0] value);
    if (mid_command) begin
      send_byte(8'($urandom_range(255)));
    end
    send_byte(sel);
    while ($urandom_range(9) == 0) send_item(1'b0, 8'($urandom_range(255)));
    send_byte(value);
  endtask

  // Mostly well-formed commands, with empty ticks and stray bytes mixed in
  task automatic send_random;
    int unsigned pick;
    logic [7:0]  sel;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(2))
        0:       sel = SEL_RED;
        1:       sel = SEL_GREEN;
        default: sel = SEL_BLUE;
      endcase
      send_command(sel, 8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_item(1'b0, 8'($urandom_range(255)));
    end else if (pick < 90) begin
      send_byte(SEL_NONE);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // Wait for all results, let the pipeline settle, then write the gain
  task automatic drain_and_write(input logic [GainBits-1:0] gain);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_wen_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [GainBits-1:0] gain, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned count);
    int unsigned goal;
    drain_and_write(gain);
    send_idle_pct   = idle_pct;
    recv_stall_pct <= stall_pct;
    goal = items_sent + count;
    while (items_sent < goal) send_random();
  endtask

  initial begin : stimulus
    int unsigned goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, each selector, unknown and zero selectors,
    // empty ticks inside a command, slow rise toward a target
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_command(SEL_RED, 8'hFF);
    send_command(SEL_GREEN, 8'h00);
    send_command(SEL_BLUE, 8'h80);
    send_byte(8'h78);
    send_byte(8'h4D);
    send_byte(SEL_NONE);
    send_command(SEL_GREEN, 8'hC8);
    send_byte(SEL_RED);
    send_item(1'b0, SEL_BLUE);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_command(SEL_BLUE, 8'h00);
    send_command(SEL_RED, 8'h01);
    repeat (3) send_item(1'b0, 8'h00);

    // Random phases over gain extremes and idle/stall mixes
    run_phase(16'hFFFF, 0, 0, 150);
    run_phase(16'd1, 56, 0, 150);
    run_phase(GainBits'($urandom_range(65535, 1)), 0, 56, 200);
    run_phase(16'd0, 8, 8, 60);
    run_phase(GainBits'($urandom_range(65535, 1)), 8, 8, 150);

    // Hold the output for a long stretch while input keeps coming
    drain_and_write(GAIN_RESET);
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    hold_requests  <= hold_requests + 1;
    goal = items_sent + 80;
    while (items_sent < goal) send_random();

    run_phase(16'h8000, 0, 0, 60);

    // Drain and give the verdict
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
